FILE: rtl/flws_pkg.sv
package flws_pkg;

	localparam int unsigned TS_W   = 32;
	localparam int unsigned SUM_W  = 64;
	localparam int unsigned CNT_W  = 32;
	localparam int unsigned RATE_W = 16;
	localparam int unsigned TAG_W  = 8;

	localparam logic [RATE_W-1:0] RATE_MAX = 16'hFFFF;

	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_ROLL   = 1'b1;

	localparam logic PATH_DIRECT  = 1'b0;
	localparam logic PATH_MUTATED = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic record;     // apply a record transaction and load the snapshot
		logic div_start;  // start a window-average division
		logic div_sel;    // path the division or save refers to
		logic save_avg;   // store the finished average
		logic commit;     // close the window and load the snapshot
	} flws_cmd_t;

	typedef struct packed {
		logic div_done;
	} flws_stat_t;

	function automatic logic [RATE_W-1:0] sat_rate(input logic [CNT_W-1:0] v);
		sat_rate = (|v[CNT_W-1:RATE_W]) ? RATE_MAX : v[RATE_W-1:0];
	endfunction

endpackage

FILE: rtl/flws_div.sv
module flws_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [flws_pkg::SUM_W-1:0]  dividend,
	input  logic [flws_pkg::CNT_W-1:0]  divisor,
	output logic                        done,
	output logic [flws_pkg::CNT_W-1:0]  quotient
);
	import flws_pkg::*;

	localparam int unsigned STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  quo_q;
	logic [STEP_W-1:0] steps_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0] trial;
	logic           fits;

	// One restoring step per cycle; only the low quotient bits are kept.
	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				steps_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				steps_q <= steps_q - STEP_W'(1);
				if (steps_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			rem_q <= fits ? CNT_W'(trial - {1'b0, dsr_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[CNT_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/flws_dp.sv
module flws_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  flws_pkg::flws_cmd_t          cmd,
	output flws_pkg::flws_stat_t         stat,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic                         mutated_path,
	input  logic                         replay_injected,
	input  logic [flws_pkg::TS_W-1:0]    rx_time_us,
	input  logic [flws_pkg::TS_W-1:0]    start_us,
	input  logic [flws_pkg::TS_W-1:0]    end_us,
	input  logic [flws_pkg::TAG_W-1:0]   rules_applied,
	input  logic [flws_pkg::TAG_W-1:0]   signals_decoded,
	output logic [flws_pkg::CNT_W-1:0]   direct_avg_latency_us,
	output logic [flws_pkg::RATE_W-1:0]  direct_frames_per_sec,
	output logic [flws_pkg::CNT_W-1:0]   mutated_avg_latency_us,
	output logic [flws_pkg::RATE_W-1:0]  mutated_frames_per_sec,
	output logic [flws_pkg::RATE_W-1:0]  forwarded_per_sec,
	output logic [flws_pkg::CNT_W-1:0]   fwd_frames_total,
	output logic [flws_pkg::CNT_W-1:0]   passive_total,
	output logic [flws_pkg::CNT_W-1:0]   replay_total,
	output logic [flws_pkg::CNT_W-1:0]   rules_applied_total,
	output logic [flws_pkg::CNT_W-1:0]   decoded_total
);
	import flws_pkg::*;

	logic              tx_en_q;
	logic [SUM_W-1:0]  dir_sum_q, mut_sum_q;
	logic [CNT_W-1:0]  dir_cnt_q, mut_cnt_q;
	logic [CNT_W-1:0]  fwd_cnt_q, fwd_last_q, pas_cnt_q, rep_cnt_q, rul_cnt_q, dec_cnt_q;
	logic [CNT_W-1:0]  dir_avg_q, mut_avg_q;

	logic [TS_W-1:0]   lat;
	logic              add_dir, add_mut, is_rep;
	logic [SUM_W-1:0]  dir_sum_d, mut_sum_d;
	logic [CNT_W-1:0]  dir_cnt_d, mut_cnt_d;
	logic [CNT_W-1:0]  fwd_cnt_d, pas_cnt_d, rep_cnt_d, rul_cnt_d, dec_cnt_d;
	logic [SUM_W-1:0]  div_dvd;
	logic [CNT_W-1:0]  div_dsr;
	logic [CNT_W-1:0]  div_quo;
	logic [CNT_W-1:0]  avg_val;
	logic              div_done;

	assign lat     = replay_injected ? (end_us - start_us) : (end_us - rx_time_us);
	assign add_dir = (mutated_path == PATH_DIRECT) && tx_en_q;
	assign add_mut = (mutated_path == PATH_MUTATED) && tx_en_q;
	assign is_rep  = replay_injected;

	always_comb begin
		dir_sum_d = add_dir ? dir_sum_q + SUM_W'(lat) : dir_sum_q;
		dir_cnt_d = add_dir ? dir_cnt_q + CNT_W'(1) : dir_cnt_q;
		mut_sum_d = add_mut ? mut_sum_q + SUM_W'(lat) : mut_sum_q;
		mut_cnt_d = add_mut ? mut_cnt_q + CNT_W'(1) : mut_cnt_q;
		fwd_cnt_d = fwd_cnt_q + CNT_W'(1);
		pas_cnt_d = (mutated_path == PATH_DIRECT) ? pas_cnt_q + CNT_W'(1) : pas_cnt_q;
		rep_cnt_d = is_rep ? rep_cnt_q + CNT_W'(1) : rep_cnt_q;
		rul_cnt_d = (mutated_path == PATH_MUTATED) ? rul_cnt_q + CNT_W'(rules_applied)
		                                           : rul_cnt_q;
		dec_cnt_d = (mutated_path == PATH_MUTATED) ? dec_cnt_q + CNT_W'(signals_decoded)
		                                           : dec_cnt_q;
	end

	assign div_dvd = (cmd.div_sel == PATH_MUTATED) ? mut_sum_q : dir_sum_q;
	assign div_dsr = (cmd.div_sel == PATH_MUTATED) ? mut_cnt_q : dir_cnt_q;
	// An empty window averages to zero.
	assign avg_val = (div_dsr == '0) ? '0 : div_quo;

	flws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign stat.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_en_q    <= 1'b0;
			dir_sum_q  <= '0;
			mut_sum_q  <= '0;
			dir_cnt_q  <= '0;
			mut_cnt_q  <= '0;
			fwd_cnt_q  <= '0;
			fwd_last_q <= '0;
			pas_cnt_q  <= '0;
			rep_cnt_q  <= '0;
			rul_cnt_q  <= '0;
			dec_cnt_q  <= '0;
			dir_avg_q  <= '0;
			mut_avg_q  <= '0;
		end else begin
			if (cfg_we) begin
				tx_en_q <= cfg_wdata;
			end
			if (cmd.record) begin
				dir_sum_q <= dir_sum_d;
				dir_cnt_q <= dir_cnt_d;
				mut_sum_q <= mut_sum_d;
				mut_cnt_q <= mut_cnt_d;
				fwd_cnt_q <= fwd_cnt_d;
				pas_cnt_q <= pas_cnt_d;
				rep_cnt_q <= rep_cnt_d;
				rul_cnt_q <= rul_cnt_d;
				dec_cnt_q <= dec_cnt_d;
			end
			if (cmd.save_avg) begin
				if (cmd.div_sel == PATH_MUTATED) begin
					mut_avg_q <= avg_val;
				end else begin
					dir_avg_q <= avg_val;
				end
			end
			if (cmd.commit) begin
				dir_sum_q  <= '0;
				dir_cnt_q  <= '0;
				mut_sum_q  <= '0;
				mut_cnt_q  <= '0;
				fwd_last_q <= fwd_cnt_q;
			end
		end
	end

	// Snapshot register, loaded when a transaction completes.
	logic [CNT_W-1:0]  snap_dir_avg_q, snap_mut_avg_q;
	logic [RATE_W-1:0] snap_dir_rate_q, snap_mut_rate_q, snap_fwd_rate_q;
	logic [CNT_W-1:0]  snap_fwd_q, snap_pas_q, snap_rep_q, snap_rul_q, snap_dec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_dir_avg_q  <= '0;
			snap_mut_avg_q  <= '0;
			snap_dir_rate_q <= '0;
			snap_mut_rate_q <= '0;
			snap_fwd_rate_q <= '0;
			snap_fwd_q      <= '0;
			snap_pas_q      <= '0;
			snap_rep_q      <= '0;
			snap_rul_q      <= '0;
			snap_dec_q      <= '0;
		end else if (cmd.record) begin
			snap_fwd_q <= fwd_cnt_d;
			snap_pas_q <= pas_cnt_d;
			snap_rep_q <= rep_cnt_d;
			snap_rul_q <= rul_cnt_d;
			snap_dec_q <= dec_cnt_d;
		end else if (cmd.commit) begin
			snap_dir_avg_q  <= dir_avg_q;
			snap_mut_avg_q  <= mut_avg_q;
			snap_dir_rate_q <= sat_rate(dir_cnt_q);
			snap_mut_rate_q <= sat_rate(mut_cnt_q);
			snap_fwd_rate_q <= sat_rate(fwd_cnt_q - fwd_last_q);
			snap_fwd_q      <= fwd_cnt_q;
			snap_pas_q      <= pas_cnt_q;
			snap_rep_q      <= rep_cnt_q;
			snap_rul_q      <= rul_cnt_q;
			snap_dec_q      <= dec_cnt_q;
		end
	end

	assign direct_avg_latency_us  = snap_dir_avg_q;
	assign direct_frames_per_sec  = snap_dir_rate_q;
	assign mutated_avg_latency_us = snap_mut_avg_q;
	assign mutated_frames_per_sec = snap_mut_rate_q;
	assign forwarded_per_sec      = snap_fwd_rate_q;
	assign fwd_frames_total       = snap_fwd_q;
	assign passive_total          = snap_pas_q;
	assign replay_total           = snap_rep_q;
	assign rules_applied_total    = snap_rul_q;
	assign decoded_total          = snap_dec_q;

endmodule

FILE: rtl/flws_ctrl.sv
module flws_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   func,
	output logic                   out_valid,
	input  logic                   out_stall,
	output flws_pkg::flws_cmd_t    cmd,
	input  flws_pkg::flws_stat_t   stat
);
	import flws_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_DIR,
		ST_START_MUT,
		ST_DIV_MUT,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_busy;
	logic   accept;
	logic   snap_load;

	// The snapshot register is free when empty or being drained this cycle.
	assign slot_busy = out_valid_q && out_stall;
	assign in_stall  = (state_q != ST_IDLE) || slot_busy;
	assign accept    = in_valid && !in_stall;
	assign snap_load = cmd.record || cmd.commit;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.record    = accept && (func == FUNC_RECORD);
				cmd.div_start = accept && (func == FUNC_ROLL);
				cmd.div_sel   = PATH_DIRECT;
			end
			ST_DIV_DIR: begin
				cmd.div_sel  = PATH_DIRECT;
				cmd.save_avg = stat.div_done;
			end
			ST_START_MUT: begin
				cmd.div_sel   = PATH_MUTATED;
				cmd.div_start = 1'b1;
			end
			ST_DIV_MUT: begin
				cmd.div_sel  = PATH_MUTATED;
				cmd.save_avg = stat.div_done;
			end
			ST_FINISH: begin
				cmd.commit = !slot_busy;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (snap_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (func == FUNC_ROLL)) begin
						state_q <= ST_DIV_DIR;
					end
				end
				ST_DIV_DIR: begin
					if (stat.div_done) begin
						state_q <= ST_START_MUT;
					end
				end
				ST_START_MUT: begin
					state_q <= ST_DIV_MUT;
				end
				ST_DIV_MUT: begin
					if (stat.div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!slot_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/forwarding_latency_window_stats_top.sv
// Traffic statistics for a frame gateway. A record transaction (func 0) updates the
// lifetime counters and, with tx_enabled set, the latency window of its path, and its
// snapshot appears in the output register on the next cycle. A roll transaction
// (func 1) computes each path's window average in a shared restoring divider that
// resolves one quotient bit per cycle, after which the windows close and the snapshot
// is loaded. Every transaction returns exactly one snapshot. Input is stalled while
// a roll is in progress. A new transaction is taken while the previous snapshot is
// being drained; a stalled snapshot holds off further input.
module forwarding_latency_window_stats_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         func,
	input  logic                         mutated_path,
	input  logic                         replay_injected,
	input  logic [flws_pkg::TS_W-1:0]    rx_time_us,
	input  logic [flws_pkg::TS_W-1:0]    start_us,
	input  logic [flws_pkg::TS_W-1:0]    end_us,
	input  logic [flws_pkg::TAG_W-1:0]   rules_applied,
	input  logic [flws_pkg::TAG_W-1:0]   signals_decoded,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [flws_pkg::CNT_W-1:0]   direct_avg_latency_us,
	output logic [flws_pkg::RATE_W-1:0]  direct_frames_per_sec,
	output logic [flws_pkg::CNT_W-1:0]   mutated_avg_latency_us,
	output logic [flws_pkg::RATE_W-1:0]  mutated_frames_per_sec,
	output logic [flws_pkg::RATE_W-1:0]  forwarded_per_sec,
	output logic [flws_pkg::CNT_W-1:0]   fwd_frames_total,
	output logic [flws_pkg::CNT_W-1:0]   passive_total,
	output logic [flws_pkg::CNT_W-1:0]   replay_total,
	output logic [flws_pkg::CNT_W-1:0]   rules_applied_total,
	output logic [flws_pkg::CNT_W-1:0]   decoded_total
);
	import flws_pkg::*;

	flws_cmd_t  cmd;
	flws_stat_t stat;

	flws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	flws_dp u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.stat                   (stat),
		.cfg_we                 (cfg_we),
		.cfg_wdata              (cfg_wdata),
		.mutated_path           (mutated_path),
		.replay_injected        (replay_injected),
		.rx_time_us             (rx_time_us),
		.start_us               (start_us),
		.end_us                 (end_us),
		.rules_applied          (rules_applied),
		.signals_decoded        (signals_decoded),
		.direct_avg_latency_us  (direct_avg_latency_us),
		.direct_frames_per_sec  (direct_frames_per_sec),
		.mutated_avg_latency_us (mutated_avg_latency_us),
		.mutated_frames_per_sec (mutated_frames_per_sec),
		.forwarded_per_sec      (forwarded_per_sec),
		.fwd_frames_total       (fwd_frames_total),
		.passive_total          (passive_total),
		.replay_total           (replay_total),
		.rules_applied_total    (rules_applied_total),
		.decoded_total          (decoded_total)
	);

endmodule
